@@ hdl/slm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types and constants of the SQL literal masker: the decision item
// that travels from the window front end to the masking back end, and the
// scan and output codes.
// ----------------------------------------------------------------------------
package slm_pkg;

    localparam int BYTE_W    = 8;
    localparam int WIN_DEPTH = 4;              // held look-ahead bytes
    localparam int SPAN      = WIN_DEPTH + 1;  // bytes visible to one decision
    localparam int PEND_W    = 3;              // holds 0..WIN_DEPTH
    localparam int CAP_W     = 16;             // output capacity register width
    localparam logic [CAP_W-1:0] CAP_RESET = 16'd1024;

    typedef logic [BYTE_W-1:0] byte_t;

    // Character codes with a special meaning in the text stream
    localparam byte_t END_BYTE  = 8'h00;       // string terminator
    localparam byte_t CH_MASK   = 8'h3F;       // '?'
    localparam byte_t CH_ESC    = 8'h5C;       // backslash
    localparam byte_t CH_SQUOTE = 8'h27;
    localparam byte_t CH_DQUOTE = 8'h22;

    // Scan mode of the back end
    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_SQUOTE,
        MODE_DQUOTE,
        MODE_NUMBER
    } mode_t;

    // Front end sequencer
    typedef enum logic {
        FE_FILL,
        FE_FLUSH
    } fe_state_t;

    // Output operation held in the back end's output stage
    typedef enum logic [1:0] {
        OP_BYTE,
        OP_TRIPLE,
        OP_TERM
    } op_kind_t;

    // One decision: byte 0 is decided on, the rest are the following bytes.
    // avail counts the valid bytes; term marks the end-of-string item.
    typedef struct packed {
        logic                   term;
        logic [PEND_W-1:0]      avail;
        logic [SPAN-1:0][BYTE_W-1:0] bytes;
    } dec_t;

endpackage

@@ hdl/slm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_front
// Input side: collects bytes into the four-byte look-ahead window and issues
// one decision item per byte that leaves the window. A zero byte starts a
// flush that drains the window and then issues the terminator item.
// ----------------------------------------------------------------------------
module slm_front
    import slm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  byte_t in_byte,
    input  logic  in_valid,
    output logic  in_stall,
    output logic  dec_push,
    output dec_t  dec_item,
    input  logic  q_full
);

    fe_state_t               state_reg, state_next;
    byte_t [WIN_DEPTH-1:0]   win_reg;
    logic  [PEND_W-1:0]      pend_reg;
    logic                    in_fire;
    logic                    in_zero;
    logic                    win_full;

    assign in_fire  = in_valid && !in_stall;
    assign in_zero  = (in_byte == '0);
    assign win_full = (pend_reg == PEND_W'(WIN_DEPTH));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FE_FILL:
            begin
                if (in_fire && in_zero)
                    state_next = FE_FLUSH;
            end
            FE_FLUSH:
            begin
                if (!q_full && pend_reg == '0)
                    state_next = FE_FILL;
            end
            default: state_next = FE_FILL;
        endcase
    end

    // Outputs: stall, decision push and its contents
    always_comb
    begin
        in_stall = 1'b0;
        dec_push = 1'b0;
        dec_item = '0;
        for (int k = 0; k < WIN_DEPTH; k++)
            dec_item.bytes[k] = win_reg[k];
        case (state_reg)
            FE_FILL:
            begin
                in_stall             = q_full;
                dec_push             = in_fire && !in_zero && win_full;
                dec_item.bytes[SPAN-1] = in_byte;
                dec_item.avail       = PEND_W'(SPAN);
            end
            FE_FLUSH:
            begin
                in_stall       = 1'b1;
                dec_push       = !q_full;
                dec_item.avail = pend_reg;
                dec_item.term  = (pend_reg == '0);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FE_FILL;
        else
            state_reg <= state_next;
    end

    // Fill, advance and drain the window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            pend_reg <= '0;
        end
        else if (state_reg == FE_FILL && in_fire && !in_zero)
        begin
            if (!win_full)
            begin
                win_reg[pend_reg[1:0]] <= in_byte;
                pend_reg               <= pend_reg + 1'b1;
            end
            else
            begin
                for (int k = 0; k < WIN_DEPTH - 1; k++)
                    win_reg[k] <= win_reg[k+1];
                win_reg[WIN_DEPTH-1] <= in_byte;
            end
        end
        else if (state_reg == FE_FLUSH && !q_full && pend_reg != '0)
        begin
            for (int k = 0; k < WIN_DEPTH - 1; k++)
                win_reg[k] <= win_reg[k+1];
            win_reg[WIN_DEPTH-1] <= '0;
            pend_reg             <= pend_reg - 1'b1;
        end
    end

endmodule

@@ hdl/slm_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_queue
// Short queue of decision items between the front end and the back end, so
// that each side can stall on its own.
// ----------------------------------------------------------------------------
module slm_queue
    import slm_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  dec_t push_item,
    output logic full,
    input  logic pop,
    output dec_t head,
    output logic head_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dec_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_ptr_reg];

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

@@ hdl/slm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_back
// Masking engine: takes one decision item per cycle while the output stage
// can take its result; tracks quote, number and keyword-skip state and the
// output budget, and drives the output stage, which plays a quote triple out.
// ----------------------------------------------------------------------------
module slm_back
    import slm_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  dec_t             dec_item,
    input  logic             dec_valid,
    output logic             dec_pop,
    input  logic [CAP_W-1:0] capacity,
    output byte_t            out_byte,
    output logic             last,
    output logic             out_valid,
    input  logic             out_stall
);

    localparam int CMP_W = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 2;
    localparam logic [3:0][7:0] KW_NULL  = {8'h4C, 8'h4C, 8'h55, 8'h4E};
    localparam logic [3:0][7:0] KW_TRUE  = {8'h45, 8'h55, 8'h52, 8'h54};
    localparam logic [4:0][7:0] KW_FALSE = {8'h45, 8'h53, 8'h4C, 8'h41, 8'h46};

    function automatic byte_t to_upper(input byte_t c);
        return (c inside {[8'h61:8'h7A]}) ? (c - 8'd32) : c;
    endfunction

    function automatic logic is_digit(input byte_t c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_num_char(input byte_t c);
        return c inside {[8'h30:8'h39], 8'h2E, 8'h65, 8'h45, 8'h2B, 8'h2D};
    endfunction

    function automatic logic is_separator(input byte_t c);
        return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
                         8'h3D, 8'h2C, 8'h28, 8'h3E, 8'h3C};
    endfunction

    // Stream state
    mode_t                 mode_reg, mode_next;
    logic                  pb_reg, pb_next;
    logic [2:0]            skip_reg, skip_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    byte_t                 lastem_reg, lastem_next;

    // Output stage
    logic                  op_valid_reg;
    op_kind_t              op_kind_reg;
    byte_t                 op_byte_reg;
    logic [1:0]            op_idx_reg;

    // Decision results
    logic                  emit;
    op_kind_t              emit_kind;
    byte_t                 emit_byte;

    byte_t                 c;
    logic                  bs;
    logic [CMP_W-1:0]      cnt_x;
    logic [CMP_W-1:0]      cap_x;
    logic [CMP_W-1:0]      cmax_x;
    logic [CMP_W-1:0]      sum1;
    logic [CMP_W-1:0]      sum3;
    logic                  room2;
    logic                  room3;
    logic                  kw4;
    logic                  kw5;
    logic                  m_null;
    logic                  m_true;
    logic                  m_false;
    logic                  finishing;
    logic                  stage_free;

    assign c      = dec_item.bytes[0];
    assign bs     = (c == CH_ESC);
    assign cnt_x  = CMP_W'(cnt_reg);
    assign cap_x  = CMP_W'(capacity);
    assign cmax_x = CMP_W'({COUNT_BITS{1'b1}});
    assign sum1   = cnt_x + CMP_W'(1);
    assign sum3   = cnt_x + CMP_W'(3);
    assign room2  = (cnt_x + CMP_W'(2)) < cap_x;
    assign room3  = sum3 < cap_x;

    // Match keywords against the visible bytes
    always_comb
    begin
        m_null  = 1'b1;
        m_true  = 1'b1;
        m_false = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            if (to_upper(dec_item.bytes[k]) != KW_NULL[k])
                m_null = 1'b0;
            if (to_upper(dec_item.bytes[k]) != KW_TRUE[k])
                m_true = 1'b0;
        end
        for (int k = 0; k < 5; k++)
        begin
            if (to_upper(dec_item.bytes[k]) != KW_FALSE[k])
                m_false = 1'b0;
        end
    end

    assign kw4 = (dec_item.avail >= PEND_W'(4)) && (m_null || m_true);
    assign kw5 = (dec_item.avail >= PEND_W'(5)) && m_false;

    // Decide on the head byte
    always_comb
    begin
        mode_next   = mode_reg;
        pb_next     = pb_reg;
        skip_next   = skip_reg;
        cnt_next    = cnt_reg;
        lastem_next = lastem_reg;
        emit        = 1'b0;
        emit_kind   = OP_BYTE;
        emit_byte   = c;
        if (dec_item.term)
        begin
            emit        = 1'b1;
            emit_kind   = OP_TERM;
            emit_byte   = END_BYTE;
            mode_next   = MODE_TEXT;
            pb_next     = 1'b0;
            skip_next   = '0;
            cnt_next    = '0;
            lastem_next = '0;
        end
        else if (skip_reg != '0)
        begin
            skip_next = skip_reg - 1'b1;
            pb_next   = bs;
        end
        else if (mode_reg == MODE_SQUOTE || mode_reg == MODE_DQUOTE)
        begin
            if (!pb_reg && ((mode_reg == MODE_SQUOTE && c == CH_SQUOTE) ||
                            (mode_reg == MODE_DQUOTE && c == CH_DQUOTE)))
                mode_next = MODE_TEXT;
            pb_next = bs;
        end
        else if (mode_reg == MODE_NUMBER && is_num_char(c))
        begin
            pb_next = bs;
        end
        else
        begin
            mode_next = MODE_TEXT;
            pb_next   = bs;
            if (room2)
            begin
                if (c == CH_SQUOTE || c == CH_DQUOTE)
                begin
                    mode_next = (c == CH_SQUOTE) ? MODE_SQUOTE : MODE_DQUOTE;
                    if (room3)
                    begin
                        emit        = 1'b1;
                        emit_kind   = OP_TRIPLE;
                        cnt_next    = (sum3 > cmax_x) ? {COUNT_BITS{1'b1}}
                                                      : sum3[COUNT_BITS-1:0];
                        lastem_next = c;
                    end
                end
                else
                begin
                    emit        = 1'b1;
                    cnt_next    = (sum1 > cmax_x) ? {COUNT_BITS{1'b1}}
                                                  : sum1[COUNT_BITS-1:0];
                    if (is_digit(c) && cnt_reg != '0 && is_separator(lastem_reg))
                    begin
                        emit_byte = CH_MASK;
                        mode_next = MODE_NUMBER;
                    end
                    else if (kw4)
                    begin
                        emit_byte = CH_MASK;
                        skip_next = 3'd3;
                    end
                    else if (kw5)
                    begin
                        emit_byte = CH_MASK;
                        skip_next = 3'd4;
                    end
                    lastem_next = emit_byte;
                end
            end
        end
    end

    // Take a decision when its output, if any, has a place to go
    assign finishing  = op_valid_reg && !out_stall &&
                        (op_kind_reg != OP_TRIPLE || op_idx_reg == 2'd2);
    assign stage_free = !op_valid_reg || finishing;
    assign dec_pop    = dec_valid && (stage_free || !emit);

    // Drive the output channel
    assign out_valid = op_valid_reg;
    assign last      = (op_kind_reg == OP_TERM);
    assign out_byte  = (op_kind_reg == OP_TRIPLE && op_idx_reg == 2'd1) ? CH_MASK
                                                                          : op_byte_reg;

    // Advance stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_TEXT;
            pb_reg     <= 1'b0;
            skip_reg   <= '0;
            cnt_reg    <= '0;
            lastem_reg <= '0;
        end
        else if (dec_pop)
        begin
            mode_reg   <= mode_next;
            pb_reg     <= pb_next;
            skip_reg   <= skip_next;
            cnt_reg    <= cnt_next;
            lastem_reg <= lastem_next;
        end
    end

    // Load, step and drop the output operation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
            op_kind_reg  <= OP_BYTE;
            op_idx_reg   <= '0;
        end
        else if (dec_pop && emit)
        begin
            op_valid_reg <= 1'b1;
            op_kind_reg  <= emit_kind;
            op_idx_reg   <= '0;
        end
        else if (finishing)
        begin
            op_valid_reg <= 1'b0;
        end
        else if (op_valid_reg && !out_stall)
        begin
            op_idx_reg <= op_idx_reg + 1'b1;
        end
    end

    // Output byte payload
    always_ff @(posedge clk)
    begin
        if (dec_pop && emit)
            op_byte_reg <= emit_byte;
    end

endmodule

@@ hdl/sql_literal_masker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_literal_masker
// Streaming SQL literal masker: quoted strings, numbers and NULL/TRUE/FALSE
// are replaced by '?' in a byte stream ended by a zero byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_byte, in_valid, in_stall): one byte per cycle unless
//   in_stall. Output (out_byte, last, out_valid, out_stall): one byte per
//   cycle unless out_stall; last marks the zero terminator.
//   cfg_data/cfg_valid/cfg_ready write out_capacity (reset 1024); write it
//   only while no string is in flight. cfg_ready is always high.
// Decision: a byte is decided once four later bytes have arrived (look-ahead
//   window); its output passes the decision queue and then the output stage.
// Throughput: one item per cycle while nothing stalls. A quote triple holds
//   the output stage until its three bytes are out. A zero byte holds in_stall
//   high while the window drains and the terminator is queued.
// Reset clears the window, the decision queue and all scan state.
// When the receiver stalls, the output stage holds its item, the decision
//   queue fills, and in_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module sql_literal_masker
    import slm_pkg::*;
#(
    parameter int COUNT_BITS  = 16,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       in_byte,
    input  logic             in_valid,
    output logic             in_stall,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic             out_valid,
    input  logic             out_stall,
    input  logic [CAP_W-1:0] cfg_data,
    input  logic             cfg_valid,
    output logic             cfg_ready
);

    logic [CAP_W-1:0] cap_reg;
    logic             dec_push;
    dec_t             dec_in;
    logic             q_full;
    logic             dec_pop;
    dec_t             dec_head;
    logic             dec_valid;

    assign cfg_ready = 1'b1;

    // Hold the output capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_valid && cfg_ready)
            cap_reg <= cfg_data;
    end

    slm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_byte  (in_byte),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .dec_push (dec_push),
        .dec_item (dec_in),
        .q_full   (q_full)
    );

    slm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (dec_push),
        .push_item  (dec_in),
        .full       (q_full),
        .pop        (dec_pop),
        .head       (dec_head),
        .head_valid (dec_valid)
    );

    slm_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_item  (dec_head),
        .dec_valid (dec_valid),
        .dec_pop   (dec_pop),
        .capacity  (cap_reg),
        .out_byte  (out_byte),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

@@ tb/tb_sql_literal_masker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sql_literal_masker
// Self-checking bench for the SQL literal masker. Zero-terminated SQL strings
// go in one byte per item, a scoreboard predicts the masked output byte by
// byte, and every accepted output item is compared in order. Output capacity
// is swept between strings, and both channels idle or stall at random.
// ----------------------------------------------------------------------------
import slm_pkg::*;

typedef byte_t text_t[$];

class masker_scoreboard;
    localparam int unsigned COUNT_MAX = 65535;

    int unsigned capacity;
    byte_t       window[WIN_DEPTH];
    int unsigned held;
    mode_t       mode;
    bit          after_escape;
    int unsigned skip_left;
    int unsigned written;
    byte_t       last_text;
    byte_t       want_byte[$];
    bit          want_last[$];
    int          errors;

    function new();
        capacity = 32'(CAP_RESET);
        errors   = 0;
        clear_stream();
    endfunction

    function void clear_stream();
        foreach (window[k]) window[k] = '0;
        held         = 0;
        mode         = MODE_TEXT;
        after_escape = 1'b0;
        skip_left    = 0;
        written      = 0;
        last_text    = '0;
    endfunction

    function int unsigned pending();
        return want_byte.size();
    endfunction

    function void emit_text(byte_t b);
        want_byte.push_back(b);
        want_last.push_back(1'b0);
        if (written < COUNT_MAX)
            written++;
        last_text = b;
    endfunction

    function byte_t upcase(byte_t b);
        return (b >= "a" && b <= "z") ? byte_t'(b - 8'd32) : b;
    endfunction

    function bit keyword_at(byte_t span[SPAN], int unsigned n, string kw);
        if (n < kw.len())
            return 1'b0;
        for (int k = 0; k < kw.len(); k++)
            if (upcase(span[k]) != byte_t'(kw[k]))
                return 1'b0;
        return 1'b1;
    endfunction

    function bit is_number_char(byte_t c);
        return (c >= "0" && c <= "9") || c == "." || c == "e" || c == "E" ||
               c == "+" || c == "-";
    endfunction

    function bit is_separator(byte_t c);
        return (c >= 8'h09 && c <= 8'h0D) || c == " " || c == "=" || c == "," ||
               c == "(" || c == ">" || c == "<";
    endfunction

    // Decide on span[0]; span[1..n-1] are the bytes that follow it
    function void decide(byte_t span[SPAN], int unsigned n);
        byte_t c;
        byte_t q;
        bit    esc;
        c   = span[0];
        esc = (c == CH_ESC);
        // drop the tail of a matched keyword
        if (skip_left > 0)
        begin
            skip_left--;
            after_escape = esc;
            return;
        end
        // drop quoted body up to an unescaped closing quote
        if (mode == MODE_SQUOTE || mode == MODE_DQUOTE)
        begin
            q = (mode == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
            if (c == q && !after_escape)
                mode = MODE_TEXT;
            after_escape = esc;
            return;
        end
        if (mode == MODE_NUMBER)
        begin
            if (is_number_char(c))
            begin
                after_escape = esc;
                return;
            end
            mode = MODE_TEXT;
        end
        after_escape = esc;
        if (!(written + 2 < capacity))
            return;
        if (c == CH_SQUOTE || c == CH_DQUOTE)
        begin
            if (written + 3 < capacity)
            begin
                emit_text(c);
                emit_text(CH_MASK);
                emit_text(c);
            end
            mode = (c == CH_SQUOTE) ? MODE_SQUOTE : MODE_DQUOTE;
        end
        else if (c >= "0" && c <= "9" && written > 0 && is_separator(last_text))
        begin
            emit_text(CH_MASK);
            mode = MODE_NUMBER;
        end
        else if (keyword_at(span, n, "NULL") || keyword_at(span, n, "TRUE"))
        begin
            emit_text(CH_MASK);
            skip_left = 3;
        end
        else if (keyword_at(span, n, "FALSE"))
        begin
            emit_text(CH_MASK);
            skip_left = 4;
        end
        else
        begin
            emit_text(c);
        end
    endfunction

    // Advance the prediction by one accepted input byte
    function void note_input(byte_t b);
        byte_t span[SPAN];
        if (b == END_BYTE)
        begin
            // flush the window, then queue the terminator
            while (held > 0)
            begin
                for (int k = 0; k < WIN_DEPTH; k++)
                    span[k] = window[k];
                span[WIN_DEPTH] = '0;
                decide(span, held);
                for (int k = 0; k + 1 < WIN_DEPTH; k++)
                    window[k] = window[k + 1];
                window[WIN_DEPTH - 1] = '0;
                held--;
            end
            want_byte.push_back(END_BYTE);
            want_last.push_back(1'b1);
            clear_stream();
            return;
        end
        if (held < WIN_DEPTH)
        begin
            window[held] = b;
            held++;
            return;
        end
        for (int k = 0; k < WIN_DEPTH; k++)
            span[k] = window[k];
        span[WIN_DEPTH] = b;
        decide(span, SPAN);
        for (int k = 0; k < WIN_DEPTH; k++)
            window[k] = span[k + 1];
    endfunction

    task report(string what);
        if (errors < 40)
            $display("[tb] mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    task check_result(byte_t got_byte, bit got_last);
        byte_t exp_byte;
        bit    exp_last;
        if (want_byte.size() == 0)
        begin
            report($sformatf("unexpected output 0x%02h last=%0b", got_byte, got_last));
            return;
        end
        exp_byte = want_byte.pop_front();
        exp_last = want_last.pop_front();
        if (got_byte != exp_byte)
            report($sformatf("out_byte 0x%02h, want 0x%02h", got_byte, exp_byte));
        if (got_last != exp_last)
            report($sformatf("last %0b, want %0b", got_last, exp_last));
    endtask
endclass

module tb_sql_literal_masker;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int BYTE_TARGET  = 410;
    localparam int DRAIN_CYCLES = 12;
    localparam logic [CAP_W-1:0] CAP_SWEEP [10] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'hFFFF, 16'd6, 16'd8, 16'd1024
    };

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PATTERN
    } rx_mode_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic [7:0]       in_byte;
    logic             in_valid;
    logic             in_stall;
    logic [7:0]       out_byte;
    logic             last;
    logic             out_valid;
    logic             out_stall;
    logic [CAP_W-1:0] cfg_data;
    logic             cfg_valid;
    logic             cfg_ready;

    masker_scoreboard sb;
    int unsigned      burst_left  = 0;
    int unsigned      sent_bytes  = 0;
    int unsigned      cycle_count = 0;
    int unsigned      rx_left     = 0;
    int unsigned      rx_tick     = 0;
    rx_mode_t         rx_mode     = RX_FREE;

    sql_literal_masker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (in_byte),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_byte  (out_byte),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // End the run if the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[sql_literal_masker] ERROR");
            $finish;
        end
    end

    // Check output items and stall on a changing pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(out_byte, last);
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 96);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_FREE:  out_stall <= 1'b0;
                RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
                RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
                default:  out_stall <= (rx_tick % 4 != 0);
            endcase
        end
    end

    // Send one byte; open a new burst after a random gap when the last one ran out
    task automatic push_byte(input byte_t b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        in_byte  <= b;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_input(b);
        sent_bytes++;
        burst_left--;
    endtask

    task automatic send_bytes(input text_t text);
        foreach (text[k])
            push_byte(text[k]);
        push_byte(END_BYTE);
    endtask

    // Hold the input idle until every expected item is out and the pipe is quiet
    task automatic settle();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        sb.capacity = 32'(value);
    endtask

    function automatic text_t to_bytes(input string s);
        text_t t;
        for (int k = 0; k < s.len(); k++)
            t.push_back(byte_t'(s[k]));
        return t;
    endfunction

    function automatic byte_t pick(input string set);
        return byte_t'(set[$urandom_range(0, set.len() - 1)]);
    endfunction

    // Build a string of mostly well-formed SQL tokens with some noise mixed in
    function automatic text_t build_text();
        text_t       t;
        int unsigned n;
        string       kw;
        byte_t       q;
        byte_t       other;
        repeat ($urandom_range(0, 6))
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    // keyword in mixed case, sometimes cut short
                    case ($urandom_range(0, 2))
                        0:       kw = "NULL";
                        1:       kw = "TRUE";
                        default: kw = "FALSE";
                    endcase
                    n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, kw.len()) : kw.len();
                    for (int k = 0; k < n; k++)
                        t.push_back($urandom_range(0, 1) ? byte_t'(kw[k])
                                                         : (byte_t'(kw[k]) | 8'h20));
                end
                1:
                begin
                    // quoted literal with escapes, sometimes left open
                    q     = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                    other = (q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE;
                    t.push_back(q);
                    repeat ($urandom_range(0, 5))
                    begin
                        case ($urandom_range(0, 5))
                            0: t.push_back(CH_ESC);
                            1:
                            begin
                                t.push_back(CH_ESC);
                                t.push_back(q);
                            end
                            2: t.push_back(other);
                            3: t.push_back(pick(" 7,"));
                            default: t.push_back(byte_t'($urandom_range(8'h61, 8'h7A)));
                        endcase
                    end
                    if ($urandom_range(0, 7) != 0)
                        t.push_back(q);
                end
                2:
                begin
                    // number after a separator
                    t.push_back(pick(" \011\012\013\014\015=,(><"));
                    t.push_back(pick("0123456789"));
                    repeat ($urandom_range(0, 4))
                        t.push_back(pick("0123456789.eE+-"));
                end
                3:
                begin
                    repeat ($urandom_range(1, 5))
                        t.push_back(pick("abcxyzABSELCTWHR_19"));
                    t.push_back(" ");
                end
                4: t.push_back(pick(" =,(<>*;\011\012"));
                default: t.push_back(byte_t'($urandom_range(1, 255)));
            endcase
        end
        return t;
    endfunction

    initial
    begin
        int unsigned      strings_done;
        int unsigned      sweep_idx;
        logic [CAP_W-1:0] cap_value;
        sb           = new();
        strings_done = 0;
        sweep_idx    = 0;
        rst_n        = 1'b0;
        in_byte      = '0;
        in_valid     = 1'b0;
        out_stall    = 1'b0;
        cfg_data     = '0;
        cfg_valid    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings at the reset capacity: empty string, escaped quote,
        // number with exponent, keywords in mixed case, unterminated quote
        send_bytes(to_bytes(""));
        send_bytes(to_bytes("'\\'x'"));
        send_bytes(to_bytes("=5.e+1 nUlL,falsE"));
        send_bytes(to_bytes("tRuE \"z"));

        // Random strings, sweeping the capacity every few strings
        while (sent_bytes < BYTE_TARGET)
        begin
            if (strings_done % 3 == 0)
            begin
                settle();
                if (sweep_idx < 10)
                    cap_value = CAP_SWEEP[sweep_idx];
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       cap_value = CAP_W'($urandom_range(3, 12));
                        1:       cap_value = CAP_W'($urandom_range(13, 40));
                        2:       cap_value = 16'hFFFF;
                        default: cap_value = CAP_W'($urandom_range(41, 65535));
                    endcase
                end
                sweep_idx++;
                write_capacity(cap_value);
            end
            send_bytes(build_text());
            strings_done++;
        end

        settle();
        if (sb.errors == 0)
            $display("[sql_literal_masker] OK");
        else
            $display("[sql_literal_masker] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/slm_pkg.sv
hdl/slm_front.sv
hdl/slm_queue.sv
hdl/slm_back.sv
hdl/sql_literal_masker.sv
tb/tb_sql_literal_masker.sv
